// ----- rtl/frame_fifo_with_clock_cursor_macros.svh -----
// Assertion macros shared by the frame queue RTL.
// Modules that include this file provide clk and arst_n.
`ifndef FRAME_FIFO_WITH_CLOCK_CURSOR_MACROS_SVH
`define FRAME_FIFO_WITH_CLOCK_CURSOR_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define FFCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define FFCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ffcc_pkg.sv -----
// Package for the frame queue with clock cursor.
// Holds sizes, command and status codes, and controller/datapath link types.
`default_nettype none

package ffcc_pkg;

	localparam int FRAMES   = 1024;
	localparam int FRAME_W  = $clog2(FRAMES);
	localparam int CNT_W    = $clog2(FRAMES + 1);
	localparam int FIELD_W  = 10;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_DELETE  = 2'd2,
		CMD_ADVANCE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 3'd0,
		STS_ALREADY = 3'd1,
		STS_EMPTY   = 3'd2,
		STS_NOTQ    = 3'd3,
		STS_CURSOR  = 3'd4
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic exec;
	} ffcc_ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} ffcc_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ffcc_cmd_if.sv -----
// Command channel: valid/ready handshake carrying one command word.
// Depends on ffcc_pkg for field widths.
`default_nettype none

interface ffcc_cmd_if import ffcc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [FIELD_W-1:0] frame_id;

	modport source (output valid, output cmd, output frame_id, input ready);
	modport sink (input valid, input cmd, input frame_id, output ready);
endinterface

`default_nettype wire

// ----- rtl/ffcc_res_if.sv -----
// Result channel: valid/ready handshake carrying one result word.
// Depends on ffcc_pkg for field widths.
`default_nettype none

interface ffcc_res_if import ffcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIELD_W-1:0]  frame_out;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output frame_out, output status, input ready);
	modport sink (input valid, input frame_out, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/frame_fifo_with_clock_cursor.sv -----
// Frame queue with a second-chance clock cursor. After reset the block runs a
// clearing pass over the queued-bit memory, one frame per cycle, over all
// FRAMES (1024) frames, and takes no command until it ends. Then the accept
// cycle of each command reads the link and queued-bit memories at one frame,
// and the exec state then decides, writes the memories and loads the result
// register once it is free. The next command is accepted only after that
// commit, so the block takes one command at a time; a result waits in its
// register and only stalls the commit of the following command. Every command
// gives exactly one result word. Push, pop, delete and advance report problems
// in status and leave the queue unchanged.
// Depends on ffcc_pkg, ffcc_cmd_if, ffcc_res_if, ffcc_ctrl and ffcc_dp.
`default_nettype none

module frame_fifo_with_clock_cursor import ffcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ffcc_cmd_if.sink   req,
	ffcc_res_if.source rsp
);

	ffcc_ctl_t ctl;
	ffcc_sts_t sts;
	logic      ready;

	assign req.ready = ready;

	ffcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	ffcc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.req_cmd      (req.cmd),
		.req_frame_id (req.frame_id),
		.rsp          (rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/ffcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ffcc_ctrl.sv -----
// Controller state machine for the frame queue: clear pass, accept, commit.
// Depends on ffcc_pkg and the assertion macro header.
`default_nettype none
`include "frame_fifo_with_clock_cursor_macros.svh"

module ffcc_ctrl import ffcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  ffcc_sts_t sts,
	output ffcc_ctl_t ctl
);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Drive commands to the datapath
	assign req_ready    = (state_q == S_IDLE);
	assign ctl.clr_step = (state_q == S_CLEAR);
	assign ctl.accept   = (state_q == S_IDLE) && req_valid;
	assign ctl.exec     = (state_q == S_EXEC) && sts.out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`FFCC_ASSERT_NEXT(a_accept_to_exec, ctl.accept, state_q == S_EXEC, "accept did not enter exec")
	`FFCC_ASSERT_NEXT(a_exec_to_idle, ctl.exec, state_q == S_IDLE, "commit did not return to idle")
	`FFCC_ASSERT_NEXT(a_exec_holds, (state_q == S_EXEC) && !sts.out_free, state_q == S_EXEC, "stalled commit was dropped")

endmodule

`default_nettype wire

// ----- rtl/ffcc_dp.sv -----
// Datapath for the frame queue: link memories, queued bits, head/tail/count,
// clock cursor and result register. Depends on ffcc_pkg, ffcc_ram, ffcc_res_if.
`default_nettype none
`include "frame_fifo_with_clock_cursor_macros.svh"

module ffcc_dp import ffcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ffcc_ctl_t          ctl,
	output ffcc_sts_t          sts,
	input  logic [CMD_W-1:0]   req_cmd,
	input  logic [FIELD_W-1:0] req_frame_id,
	ffcc_res_if.source         rsp
);

	// Item registers
	cmd_t               cmd_q;
	logic [FRAME_W-1:0] addr_q;
	logic               range_q;

	// Queue and cursor state
	logic [FRAME_W-1:0] head_q, tail_q, cursor_q, clr_idx_q;
	logic [CNT_W-1:0]   count_q;
	logic               cursor_vld_q;

	// Result register
	logic               out_valid_q;
	logic [FIELD_W-1:0] frame_out_q;
	status_t            status_q;

	// Memory ports
	logic [FRAME_W-1:0] rd_addr, nxt_rd, prv_rd;
	logic               inq_rd;
	logic               nxt_wr, prv_wr, inq_wr, inq_wdata, do_unlink;
	logic [FRAME_W-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
	logic               inq_we, inq_wd;
	logic [FRAME_W-1:0] inq_waddr;

	// Commit values
	logic [FRAME_W-1:0] head_d, tail_d, cursor_d, res_frame, adv_frame;
	logic [CNT_W-1:0]   count_d;
	logic               cursor_vld_d;
	status_t            res_status;

	logic [FRAME_W-1:0] req_idx;
	logic               req_in_range;

	assign req_idx      = FRAME_W'(req_frame_id);
	assign req_in_range = 32'(req_frame_id) < 32'(FRAMES);

	// Pick the frame whose links the command needs
	always_comb begin
		case (cmd_t'(req_cmd))
			CMD_POP:     rd_addr = head_q;
			CMD_ADVANCE: rd_addr = cursor_q;
			default:     rd_addr = req_idx;
		endcase
	end

	// Latch the accepted word
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= cmd_t'(req_cmd);
			addr_q  <= rd_addr;
			range_q <= req_in_range;
		end
	end

	ffcc_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_next_ram (
		.clk   (clk),
		.we    (ctl.exec && nxt_wr),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.re    (ctl.accept),
		.raddr (rd_addr),
		.rdata (nxt_rd)
	);

	ffcc_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_prev_ram (
		.clk   (clk),
		.we    (ctl.exec && prv_wr),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.re    (ctl.accept),
		.raddr (rd_addr),
		.rdata (prv_rd)
	);

	// Queued bits: cleared by the sweep after reset, then written on commit
	assign inq_we    = ctl.clr_step || (ctl.exec && inq_wr);
	assign inq_waddr = ctl.clr_step ? clr_idx_q : addr_q;
	assign inq_wd    = ctl.clr_step ? 1'b0 : inq_wdata;

	ffcc_ram #(.WIDTH(1), .DEPTH(FRAMES)) u_inq_ram (
		.clk   (clk),
		.we    (inq_we),
		.waddr (inq_waddr),
		.wdata (inq_wd),
		.re    (ctl.accept),
		.raddr (rd_addr),
		.rdata (inq_rd)
	);

	// Next cursor frame wraps from the tail to the head
	assign adv_frame = (cursor_q == tail_q) ? head_q : nxt_rd;

	// Decide the command and the link updates
	always_comb begin
		head_d       = head_q;
		tail_d       = tail_q;
		cursor_d     = cursor_q;
		cursor_vld_d = cursor_vld_q;
		count_d      = count_q;
		res_frame    = '0;
		res_status   = STS_OK;
		nxt_wr       = 1'b0;
		nxt_waddr    = tail_q;
		nxt_wdata    = addr_q;
		prv_wr       = 1'b0;
		prv_waddr    = addr_q;
		prv_wdata    = '0;
		inq_wr       = 1'b0;
		inq_wdata    = 1'b0;
		do_unlink    = 1'b0;
		case (cmd_q)
			CMD_PUSH: begin
				if (!range_q) begin
					res_status = STS_NOTQ;
				end else if (inq_rd) begin
					res_status = STS_ALREADY;
				end else begin
					inq_wr    = 1'b1;
					inq_wdata = 1'b1;
					prv_wr    = 1'b1;
					if (count_q == '0) begin
						head_d       = addr_q;
						cursor_d     = addr_q;
						cursor_vld_d = 1'b1;
					end else begin
						prv_wdata = tail_q;
						nxt_wr    = 1'b1;
					end
					tail_d  = addr_q;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (count_q == '0) begin
					res_status = STS_EMPTY;
				end else begin
					do_unlink = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (!range_q || !inq_rd) begin
					res_status = STS_NOTQ;
				end else begin
					do_unlink = 1'b1;
				end
			end
			CMD_ADVANCE: begin
				if (!cursor_vld_q || !inq_rd) begin
					res_status = STS_CURSOR;
				end else begin
					cursor_d  = adv_frame;
					res_frame = adv_frame;
				end
			end
			default: begin
				res_status = STS_OK;
			end
		endcase

		// Unlink the frame; only a middle frame needs its neighbors rewired
		if (do_unlink) begin
			res_frame = addr_q;
			inq_wr    = 1'b1;
			inq_wdata = 1'b0;
			count_d   = count_q - CNT_W'(1);
			if (count_q == CNT_W'(1)) begin
				head_d = '0;
				tail_d = '0;
			end else if (addr_q == head_q) begin
				head_d = nxt_rd;
			end else if (addr_q == tail_q) begin
				tail_d = prv_rd;
			end else begin
				nxt_wr    = 1'b1;
				nxt_waddr = prv_rd;
				nxt_wdata = nxt_rd;
				prv_wr    = 1'b1;
				prv_waddr = nxt_rd;
				prv_wdata = prv_rd;
			end
		end
	end

	// Commit queue state, advance the clear sweep, track the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			cursor_q     <= '0;
			cursor_vld_q <= 1'b0;
			count_q      <= '0;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.clr_step) begin
				clr_idx_q <= clr_idx_q + FRAME_W'(1);
			end
			if (ctl.exec) begin
				head_q       <= head_d;
				tail_q       <= tail_d;
				cursor_q     <= cursor_d;
				cursor_vld_q <= cursor_vld_d;
				count_q      <= count_d;
				out_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			frame_out_q <= FIELD_W'(res_frame);
			status_q    <= res_status;
		end
	end

	assign sts.clr_last = (clr_idx_q == FRAME_W'(FRAMES - 1));
	assign sts.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid     = out_valid_q;
	assign rsp.frame_out = frame_out_q;
	assign rsp.status    = status_q;

	`FFCC_ASSERT_NOW(a_empty_ends, count_q == '0, (head_q == '0) && (tail_q == '0), "empty queue with nonzero head or tail")
	`FFCC_ASSERT_NOW(a_no_cursor_empty, !cursor_vld_q, count_q == '0, "frames queued without a cursor")
	`FFCC_ASSERT_NEXT(a_exec_result, ctl.exec, rsp.valid, "commit did not present a result")

endmodule

`default_nettype wire
